// ===== design/lpr_pkg.sv =====
// Shared constants, types and helpers for the link printer packet responder.
`timescale 1ns / 1ps
`default_nettype none

package lpr_pkg;

    localparam int unsigned ImageBufferBytes = 1024;
    localparam int unsigned SettingsBytes    = 4;

    localparam logic [7:0] CMD_PRINT = 8'h02;
    localparam logic [7:0] CMD_DATA  = 8'h04;

    // Bit positions of the printer status flags
    localparam int unsigned FLAG_CKERR  = 0;
    localparam int unsigned FLAG_BUSY   = 1;
    localparam int unsigned FLAG_FULL   = 2;
    localparam int unsigned FLAG_UNPROC = 3;

    localparam logic [15:0] SYNC_RESET   = 16'h8833;
    localparam logic [7:0]  DEVICE_RESET = 8'h81;

    localparam logic [15:0] SUM_LOW_MASK  = 16'h00FF;
    localparam logic [15:0] SUM_HIGH_MASK = 16'hFF00;

    typedef logic [16:0] t_cap;

    typedef struct packed {
        logic       reply_bit;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic       payload_valid;
        logic       payload_target;
        logic [9:0] payload_index;
        logic       packet_done;
        logic       checksum_good;
        logic [7:0] packet_command;
        logic [7:0] status_sent;
        logic       length_fault;
    } t_result;

    // Buffer capacity for a command; zero when the command has no buffer
    function automatic t_cap buffer_size(input logic [7:0] cmd);
        t_cap cap;
        cap = '0;
        if (cmd == CMD_DATA) begin
            cap = t_cap'(ImageBufferBytes);
        end else if (cmd == CMD_PRINT) begin
            cap = t_cap'(SettingsBytes);
        end
        return cap;
    endfunction

endpackage

`default_nettype wire

// ===== design/lpr_engine.sv =====
// Link state, byte assembly, packet parser and reply shifter for one pin sample.
`timescale 1ns / 1ps
`default_nettype none

module lpr_engine
    import lpr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire logic        i_clock_level,
    input  wire logic        i_data_bit,
    input  wire logic        i_print_finished,
    input  wire logic [15:0] i_sync_pattern,
    input  wire logic [7:0]  i_device_code,
    output t_result          o_result
);

    localparam logic [3:0] ST_COMMAND  = 4'd0;
    localparam logic [3:0] ST_COMPRESS = 4'd1;
    localparam logic [3:0] ST_LEN_LO   = 4'd2;
    localparam logic [3:0] ST_LEN_HI   = 4'd3;
    localparam logic [3:0] ST_PAYLOAD  = 4'd4;
    localparam logic [3:0] ST_SUM_LO   = 4'd5;
    localparam logic [3:0] ST_SUM_HI   = 4'd6;
    localparam logic [3:0] ST_DEVICE   = 4'd7;
    localparam logic [3:0] ST_STATUS   = 4'd8;

    logic        r_clock_prev, n_clock_prev;
    logic        r_first_seen, n_first_seen;
    logic        r_aligned, n_aligned;
    logic [15:0] r_preamble, n_preamble;
    logic [2:0]  r_bitpos, n_bitpos;
    logic [7:0]  r_rx, n_rx;
    logic [7:0]  r_tx_staged, n_tx_staged;
    logic [7:0]  r_tx_shift, n_tx_shift;
    logic [3:0]  r_stage, n_stage;
    logic [7:0]  r_command, n_command;
    logic [15:0] r_len, n_len;
    logic [15:0] r_count, n_count;
    logic [15:0] r_sum, n_sum;
    logic [15:0] r_rx_sum, n_rx_sum;
    logic [3:0]  r_flags, n_flags;
    logic        r_fault, n_fault;
    logic        r_reply, n_reply;

    logic [15:0] v_pre;
    logic [7:0]  v_rx;
    logic [7:0]  v_tx;
    logic [15:0] v_sum;
    logic [15:0] v_len;
    t_cap        v_cap;
    t_result     v_res;

    always_comb begin
        n_clock_prev = r_clock_prev;
        n_first_seen = r_first_seen;
        n_aligned    = r_aligned;
        n_preamble   = r_preamble;
        n_bitpos     = r_bitpos;
        n_rx         = r_rx;
        n_tx_staged  = r_tx_staged;
        n_tx_shift   = r_tx_shift;
        n_stage      = r_stage;
        n_command    = r_command;
        n_len        = r_len;
        n_count      = r_count;
        n_sum        = r_sum;
        n_rx_sum     = r_rx_sum;
        n_flags      = r_flags;
        n_fault      = r_fault;
        n_reply      = r_reply;
        v_pre        = {r_preamble[14:0], i_data_bit};
        v_rx         = r_rx | (i_data_bit ? (8'd1 << r_bitpos) : 8'd0);
        v_tx         = (r_bitpos == 3'd7) ? r_tx_staged : r_tx_shift;
        v_sum        = r_sum + {8'd0, v_rx};
        v_len        = {v_rx, r_len[7:0]};
        v_cap        = buffer_size(r_command);
        v_res        = '0;

        if (i_print_finished) begin
            n_flags[FLAG_BUSY] = 1'b0;
            n_flags[FLAG_FULL] = 1'b0;
        end

        if (!r_first_seen) begin
            n_first_seen = 1'b1;
        end else if (i_clock_level != r_clock_prev) begin
            if (i_clock_level) begin
                if (!r_aligned) begin
                    // Hunt for the preamble one bit per rising edge
                    n_preamble = v_pre;
                    if (v_pre == i_sync_pattern) begin
                        n_aligned = 1'b1;
                        n_bitpos  = 3'd7;
                        n_rx      = '0;
                    end
                end else if (r_bitpos != 3'd0) begin
                    n_rx     = v_rx;
                    n_bitpos = r_bitpos - 3'd1;
                end else begin
                    n_bitpos         = 3'd7;
                    n_rx             = '0;
                    v_res.byte_valid = 1'b1;
                    v_res.byte_value = v_rx;
                    case (r_stage)
                        ST_COMPRESS: begin
                            n_sum   = v_sum;
                            n_stage = ST_LEN_LO;
                        end
                        ST_LEN_LO: begin
                            n_len   = {8'd0, v_rx};
                            n_sum   = v_sum;
                            n_stage = ST_LEN_HI;
                        end
                        ST_LEN_HI: begin
                            n_len   = v_len;
                            n_sum   = v_sum;
                            if ((v_len != 16'd0) &&
                                ((v_cap == '0) || ({1'b0, v_len} > v_cap))) begin
                                n_fault = 1'b1;
                            end
                            n_count = '0;
                            n_stage = (v_len != 16'd0) ? ST_PAYLOAD : ST_SUM_LO;
                        end
                        ST_PAYLOAD: begin
                            n_sum = v_sum;
                            // Emit only bytes that land inside an existing buffer
                            if ((v_cap != '0) && ({1'b0, r_count} < v_cap)) begin
                                v_res.payload_valid  = 1'b1;
                                v_res.payload_target = (r_command == CMD_PRINT);
                                v_res.payload_index  = r_count[9:0];
                            end
                            n_count = r_count + 16'd1;
                            if (n_count >= r_len) begin
                                n_stage = ST_SUM_LO;
                            end
                        end
                        ST_SUM_LO: begin
                            n_rx_sum = {8'd0, v_rx} & SUM_LOW_MASK;
                            n_stage  = ST_SUM_HI;
                        end
                        ST_SUM_HI: begin
                            n_rx_sum    = r_rx_sum | ({v_rx, 8'd0} & SUM_HIGH_MASK);
                            n_tx_staged = i_device_code;
                            n_stage     = ST_DEVICE;
                        end
                        ST_DEVICE: begin
                            n_flags[FLAG_CKERR] = (r_sum != r_rx_sum);
                            if (r_command == CMD_DATA) begin
                                n_flags[FLAG_UNPROC] = 1'b1;
                            end else if (r_command == CMD_PRINT) begin
                                n_flags[FLAG_UNPROC] = 1'b0;
                                n_flags[FLAG_BUSY]   = 1'b1;
                                n_flags[FLAG_FULL]   = 1'b1;
                            end
                            n_tx_staged = {4'd0, n_flags};
                            n_stage     = ST_STATUS;
                        end
                        ST_STATUS: begin
                            // Close the packet and drop back to preamble hunt
                            v_res.packet_done   = 1'b1;
                            v_res.checksum_good = (r_sum == r_rx_sum);
                            v_res.status_sent   = r_tx_shift;
                            n_stage     = ST_COMMAND;
                            n_aligned   = 1'b0;
                            n_preamble  = '0;
                            n_bitpos    = '0;
                            n_tx_staged = '0;
                        end
                        default: begin
                            n_command = v_rx;
                            n_sum     = {8'd0, v_rx};
                            n_fault   = 1'b0;
                            n_len     = '0;
                            n_stage   = ST_COMPRESS;
                        end
                    endcase
                    v_res.length_fault = n_fault;
                end
            end else begin
                if (r_aligned) begin
                    if (r_bitpos == 3'd7) begin
                        n_tx_shift  = r_tx_staged;
                        n_tx_staged = '0;
                    end
                    n_reply = v_tx[r_bitpos];
                end else begin
                    n_reply = 1'b0;
                end
            end
        end
        n_clock_prev = i_clock_level;

        v_res.reply_bit      = n_reply;
        v_res.packet_command = n_command;
    end

    assign o_result = v_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_prev <= 1'b0;
            r_first_seen <= 1'b0;
            r_aligned    <= 1'b0;
            r_preamble   <= '0;
            r_bitpos     <= '0;
            r_rx         <= '0;
            r_tx_staged  <= '0;
            r_tx_shift   <= '0;
            r_stage      <= ST_COMMAND;
            r_command    <= '0;
            r_len        <= '0;
            r_count      <= '0;
            r_sum        <= '0;
            r_rx_sum     <= '0;
            r_flags      <= '0;
            r_fault      <= 1'b0;
            r_reply      <= 1'b0;
        end else if (i_step) begin
            r_clock_prev <= n_clock_prev;
            r_first_seen <= n_first_seen;
            r_aligned    <= n_aligned;
            r_preamble   <= n_preamble;
            r_bitpos     <= n_bitpos;
            r_rx         <= n_rx;
            r_tx_staged  <= n_tx_staged;
            r_tx_shift   <= n_tx_shift;
            r_stage      <= n_stage;
            r_command    <= n_command;
            r_len        <= n_len;
            r_count      <= n_count;
            r_sum        <= n_sum;
            r_rx_sum     <= n_rx_sum;
            r_flags      <= n_flags;
            r_fault      <= n_fault;
            r_reply      <= n_reply;
        end
    end

endmodule

`default_nettype wire

// ===== design/link_printer_packet_responder_core.sv =====
// Top level of the link printer packet responder: handshake, config and result register.
`timescale 1ns / 1ps
`default_nettype none

// Channel      Valid     Stall     Payload
// ----------   -------   -------   -----------------------------------------------
// sample in    i_valid   o_stall   i_clock_level, i_data_bit, i_print_finished
// result out   o_valid   i_stall   o_reply_bit .. o_length_fault (one per sample)
// config       i_cfg_we  (none)    i_cfg_index, i_cfg_data
//
// One sample transaction per clock is sustained while i_stall stays low; each sample goes
// input register -> engine logic -> result register, and its result is on the outputs
// once the result register has loaded it.
// Reset (i_rst_n low, synchronous) clears link state, the parser and both pipeline
// valids, and restores sync_pattern 0x8833 and device_code 0x81.
// A stall on the output holds the result register; the input register then holds
// one more sample and o_stall rises only once both stages are full.

module link_printer_packet_responder_core
    import lpr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // sample channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_clock_level,
    input  wire logic        i_data_bit,
    input  wire logic        i_print_finished,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_reply_bit,
    output logic             o_byte_valid,
    output logic [7:0]       o_byte_value,
    output logic             o_payload_valid,
    output logic             o_payload_target,
    output logic [9:0]       o_payload_index,
    output logic             o_packet_done,
    output logic             o_checksum_good,
    output logic [7:0]       o_packet_command,
    output logic [7:0]       o_status_sent,
    output logic             o_length_fault,
    // configuration port
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam logic REG_SYNC   = 1'b0;
    localparam logic REG_DEVICE = 1'b1;

    logic [15:0] r_sync;
    logic [7:0]  r_device;

    logic        r_in_valid;
    logic        r_in_clock;
    logic        r_in_data;
    logic        r_in_pf;
    logic        r_out_valid;
    t_result     r_res;
    t_result     w_res;
    logic        w_step;
    logic        w_in_ready;

    // Advance the input stage whenever the result register is free or being drained
    assign w_step     = r_in_valid && (!r_out_valid || !i_stall);
    assign w_in_ready = !r_in_valid || w_step;
    assign o_stall    = !w_in_ready;
    assign o_valid    = r_out_valid;

    // Configuration registers; the user must write them only while the block is idle (not enforced here)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync   <= SYNC_RESET;
            r_device <= DEVICE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SYNC:   r_sync   <= i_cfg_data;
                REG_DEVICE: r_device <= i_cfg_data[7:0];
                default:    r_sync   <= r_sync;
            endcase
        end
    end

    // Input register: take a sample transaction whenever the stage can move on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_in_ready) begin
            r_in_clock <= i_clock_level;
            r_in_data  <= i_data_bit;
            r_in_pf    <= i_print_finished;
        end
    end

    lpr_engine u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_step),
        .i_clock_level    (r_in_clock),
        .i_data_bit       (r_in_data),
        .i_print_finished (r_in_pf),
        .i_sync_pattern   (r_sync),
        .i_device_code    (r_device),
        .o_result         (w_res)
    );

    // Result register: load on step, drop valid once the transaction is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_res <= w_res;
        end
    end

    assign o_reply_bit      = r_res.reply_bit;
    assign o_byte_valid     = r_res.byte_valid;
    assign o_byte_value     = r_res.byte_value;
    assign o_payload_valid  = r_res.payload_valid;
    assign o_payload_target = r_res.payload_target;
    assign o_payload_index  = r_res.payload_index;
    assign o_packet_done    = r_res.packet_done;
    assign o_checksum_good  = r_res.checksum_good;
    assign o_packet_command = r_res.packet_command;
    assign o_status_sent    = r_res.status_sent;
    assign o_length_fault   = r_res.length_fault;

endmodule

`default_nettype wire
